FILE: design/gbcs_pkg.sv
// Shared types and constants for the gyro bias calibrate and subtract block.
package gbcs_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int ACC_WIDTH    = 32;
	localparam int COUNT_WIDTH  = 16;
	localparam int NUM_AXES     = 3;
	localparam int CFG_DATA_WIDTH = 16;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [ACC_WIDTH-1:0]           acc_t;
	typedef logic [COUNT_WIDTH-1:0]         count_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_START  = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_CAL_COUNT = 1'b0,
		REG_CORR_EN   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DIV  = 1'b1
	} state_t;

	typedef struct packed {
		logic    command;
		sample_t accel_x;
		sample_t accel_y;
		sample_t accel_z;
		sample_t gyro_x;
		sample_t gyro_y;
		sample_t gyro_z;
	} in_word_t;

	typedef struct packed {
		sample_t out_accel_x;
		sample_t out_accel_y;
		sample_t out_accel_z;
		sample_t out_gyro_x;
		sample_t out_gyro_y;
		sample_t out_gyro_z;
		logic    calibrating;
		logic    calibration_done;
	} out_word_t;

	typedef struct packed {
		logic   start;
		acc_t   dividend;
		count_t divisor;
	} div_req_t;

	typedef struct packed {
		logic    done;
		sample_t quotient;
	} div_rsp_t;

endpackage

FILE: design/gbcs_div.sv
// Shared bit-serial signed-by-unsigned divider, truncating toward zero.
module gbcs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  gbcs_pkg::div_req_t req,
	output gbcs_pkg::div_rsp_t rsp
);

	localparam int AW = gbcs_pkg::ACC_WIDTH;
	localparam int CW = gbcs_pkg::COUNT_WIDTH;
	localparam int SW = gbcs_pkg::SAMPLE_WIDTH;
	localparam int STEP_W = $clog2(AW);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CW-1:0]     rem_q;
	logic [AW-1:0]     quo_q;
	logic [CW-1:0]     dvs_q;
	logic              neg_q;

	logic [CW:0]   rem_sh;
	logic [CW:0]   diff;
	logic          fits;
	logic [AW-1:0] mag;
	logic [SW-1:0] quo_lo;

	assign mag    = req.dividend[AW-1] ? (-req.dividend) : req.dividend;
	assign rem_sh = {rem_q, quo_q[AW-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign fits   = !diff[CW];	// remainder stays below divisor, so sign bit is exact
	assign quo_lo = quo_q[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(AW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag;
			dvs_q <= req.divisor;
			neg_q <= req.dividend[AW-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[CW-1:0] : rem_sh[CW-1:0];
			quo_q <= {quo_q[AW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (-quo_lo) : quo_lo;

endmodule

FILE: design/gyro_bias_calibrate_subtract.sv
// Top level: gyro offset subtraction, calibration accumulators and run sequencer.
//
//  channel  | signals                          | dir | handshake
//  ---------+----------------------------------+-----+-------------------------
//  in       | in_valid in_stall in_data        | in  | word taken: valid & !stall
//  out      | out_valid out_stall out_data     | out | word taken: valid & !stall
//  cfg      | cfg_valid cfg_ready cfg_index    | in  | write: valid & ready
//           | cfg_data                         |     |
//
// A sample or start word is taken when in_stall is low; its result is held in the
// output register. The word that completes a calibration run waits while
// the three offsets go one after another through the single shared divider,
// which per axis is loaded, shifts in the quotient bits and raises done.
// Reset clears accumulators, counter, offsets and config to their defaults.
// in_stall is high during the divide and while a held result is not taken.
// cfg writes are always taken (cfg_ready tied high).
module gyro_bias_calibrate_subtract (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  gbcs_pkg::in_word_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output gbcs_pkg::out_word_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [gbcs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	localparam int NA = gbcs_pkg::NUM_AXES;
	localparam int CW = gbcs_pkg::COUNT_WIDTH;
	localparam int AW = gbcs_pkg::ACC_WIDTH;

	// configuration
	gbcs_pkg::count_t cal_count_q;
	logic             corr_en_q;

	// calibration state
	gbcs_pkg::acc_t    sum_q    [NA];
	gbcs_pkg::sample_t offset_q [NA];
	gbcs_pkg::count_t  samples_q;
	logic              calib_q;

	// sequencer
	gbcs_pkg::state_t  state_q, state_d;
	logic [1:0]        ax_q;
	logic              go_q;

	// output register and pending result of a completing word
	logic                out_valid_q;
	gbcs_pkg::out_word_t out_q;
	gbcs_pkg::out_word_t pend_q;

	gbcs_pkg::div_req_t div_req;
	gbcs_pkg::div_rsp_t div_rsp;

	// datapath
	gbcs_pkg::sample_t   gin   [NA];
	gbcs_pkg::sample_t   g     [NA];
	gbcs_pkg::acc_t      sum_d [NA];
	gbcs_pkg::count_t    samples_d;
	gbcs_pkg::count_t    cnt_eff;
	logic                accept;
	logic                is_start;
	logic                complete;
	logic                out_load;
	logic                sel_pend;
	logic                last_ax;
	gbcs_pkg::out_word_t imm_word;

	assign cfg_ready = 1'b1;

	assign gin[0] = in_data.gyro_x;
	assign gin[1] = in_data.gyro_y;
	assign gin[2] = in_data.gyro_z;

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			g[i]     = corr_en_q ? (gin[i] - offset_q[i]) : gin[i];
			sum_d[i] = sum_q[i] + AW'(g[i]);
		end
	end

	assign is_start  = (in_data.command == gbcs_pkg::CMD_START);
	assign samples_d = samples_q + 1'b1;
	assign cnt_eff   = (cal_count_q == '0) ? CW'(1) : cal_count_q;	// zero count acts as one
	assign complete  = !is_start && calib_q && (samples_d >= cnt_eff);
	assign accept    = in_valid && !in_stall;
	assign last_ax   = (ax_q == 2'(NA - 1));

	always_comb begin
		if (is_start) begin
			imm_word = '0;
			imm_word.calibrating = 1'b1;
		end else begin
			imm_word.out_accel_x      = in_data.accel_x;
			imm_word.out_accel_y      = in_data.accel_y;
			imm_word.out_accel_z      = in_data.accel_z;
			imm_word.out_gyro_x       = g[0];
			imm_word.out_gyro_y       = g[1];
			imm_word.out_gyro_z       = g[2];
			imm_word.calibrating      = calib_q && !complete;
			imm_word.calibration_done = complete;
		end
	end

	// sequencer: next state and control
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		sel_pend = 1'b0;
		in_stall = (out_valid_q && out_stall);
		div_req.start    = 1'b0;
		div_req.dividend = sum_q[ax_q];
		div_req.divisor  = cnt_eff;
		case (state_q)
			gbcs_pkg::ST_IDLE: begin
				if (accept) begin
					if (complete)
						state_d = gbcs_pkg::ST_DIV;
					else
						out_load = 1'b1;
				end
			end
			gbcs_pkg::ST_DIV: begin
				in_stall      = 1'b1;
				div_req.start = go_q;
				if (div_rsp.done && last_ax) begin
					out_load = 1'b1;
					sel_pend = 1'b1;
					state_d  = gbcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d  = gbcs_pkg::ST_IDLE;
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gbcs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_count_q <= CW'(1);
			corr_en_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (gbcs_pkg::cfg_reg_t'(cfg_index))
				gbcs_pkg::REG_CAL_COUNT: cal_count_q <= cfg_data[CW-1:0];
				gbcs_pkg::REG_CORR_EN:   corr_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// accumulators, counter and run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NA; i++)
				sum_q[i] <= '0;
			samples_q <= '0;
			calib_q   <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				for (int i = 0; i < NA; i++)
					sum_q[i] <= '0;
				samples_q <= '0;
				calib_q   <= 1'b1;
			end else if (calib_q) begin
				for (int i = 0; i < NA; i++)
					sum_q[i] <= sum_d[i];
				samples_q <= samples_d;
				if (complete)
					calib_q <= 1'b0;
			end
		end
	end

	// axis walk through the shared divider, offsets written as quotients land
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			go_q <= 1'b0;
			for (int i = 0; i < NA; i++)
				offset_q[i] <= '0;
		end else begin
			go_q <= 1'b0;
			if (state_q == gbcs_pkg::ST_IDLE && state_d == gbcs_pkg::ST_DIV) begin
				ax_q <= '0;
				go_q <= 1'b1;
			end else if (state_q == gbcs_pkg::ST_DIV && div_rsp.done) begin
				offset_q[ax_q] <= div_rsp.quotient;
				if (!last_ax) begin
					ax_q <= ax_q + 1'b1;
					go_q <= 1'b1;
				end
			end
		end
	end

	// completing word keeps the outputs made with the old offsets
	always_ff @(posedge clk) begin
		if (accept && complete)
			pend_q <= imm_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= sel_pend ? pend_q : imm_word;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	gbcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid_q && out_stall))
		else $error("held result overwritten");

	a_div_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == gbcs_pkg::ST_DIV))
		else $error("divider result outside divide phase");

	a_done_not_cal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.calibrating && out_q.calibration_done))
		else $error("run both active and done");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gbcs_pkg::ST_IDLE) |-> !div_req.start)
		else $error("divider started while idle");
`endif

endmodule
